/* hw/rtl/crc16fac_pkg.sv */
// ----------------------------------------------------------------------------
// CRC-16 frame append/check package
// Shared types, constants and the byte-wide CRC-16 update for the frame
// append/check core.
// ----------------------------------------------------------------------------
package crc16fac_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcMsb  = 16'h8000;

  localparam logic [12:0] CountMax       = 13'h1FFF;
  localparam logic [12:0] MaxPayloadInit = 13'd254;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMismatch = 2'd1,
    StOverflow = 2'd2,
    StShort    = 2'd3
  } status_t;

  typedef enum logic {
    CfgMode       = 1'b0,
    CfgMaxPayload = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        has_byte;
    logic        eof;
    status_t     status;
    logic [12:0] length;
  } result_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcMsb) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/crc16_frame_append_check_core.sv */
// ----------------------------------------------------------------------------
// CRC-16 frame append/check core
// Folds frame bytes into a CRC-16 (poly 0x1021, init 0xFFFF) and either
// appends the CRC or checks and strips a received CRC, ending each frame
// with a status transaction.
// ----------------------------------------------------------------------------
// The core takes one byte per clock while in_stall is low. Each accepted
// byte is processed in the cycle it arrives and its results, up to three,
// are written into a four-entry result queue that drives the output port one
// transaction per cycle while out_stall is low. In append mode a byte yields
// one result, except the last byte of a frame, which yields three (two when
// the CRC would not fit the buffer). In check mode the first two bytes of a
// frame are held and yield none, later bytes one and the last up to two. The
// input stalls while more than one result is queued; cfg_ready is always high.
module crc16_frame_append_check_core
  import crc16fac_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic        byte_valid,
  output logic        end_of_frame,
  output logic [1:0]  status,
  output logic [12:0] payload_length
);

  localparam logic [13:0] BufLimit = 14'(BUFFER_BYTES);

  logic              mode;
  logic [12:0]       max_payload;
  logic [15:0]       crc_acc;
  logic [7:0]        held0;
  logic [7:0]        held1;
  logic [1:0]        held_count;
  logic [12:0]       frame_count;

  logic [15:0]       crc_acc_next;
  logic [7:0]        held0_next;
  logic [7:0]        held1_next;
  logic [1:0]        held_count_next;
  logic [12:0]       fc_inc;
  logic [12:0]       len_chk;
  logic [15:0]       crc_byte;
  logic [15:0]       crc_held;

  result_t           queue [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  q_count;
  result_t           res [3];
  logic [1:0]        push_n;

  logic              acc;
  logic              pop;
  result_t           head;

  assign cfg_ready = 1'b1;
  assign in_stall  = (q_count > QCntW'(1));
  assign acc       = in_valid && !in_stall;
  assign out_valid = (q_count != '0);
  assign pop       = out_valid && !out_stall;

  assign head           = queue[rd_ptr];
  assign byte_out       = head.data;
  assign byte_valid     = head.has_byte;
  assign end_of_frame   = head.eof;
  assign status         = head.status;
  assign payload_length = head.length;

  assign fc_inc   = (frame_count != CountMax) ? frame_count + 13'd1 : frame_count;
  assign crc_byte = crc_fold(crc_acc, byte_in);
  assign crc_held = crc_fold(crc_acc, held0);
  assign len_chk  = (fc_inc >= 13'd2) ? fc_inc - 13'd2 : 13'd0;

  always_comb begin
    crc_acc_next    = crc_acc;
    held0_next      = held0;
    held1_next      = held1;
    held_count_next = held_count;
    push_n          = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '{data: 8'h00, has_byte: 1'b0, eof: 1'b0, status: StOk, length: 13'd0};
    end
    if (!mode) begin
      res[0]       = '{data: byte_in, has_byte: 1'b1, eof: 1'b0, status: StOk, length: 13'd0};
      crc_acc_next = crc_byte;
      push_n       = 2'd1;
      if (frame_end) begin
        if ({1'b0, fc_inc} + 14'd2 > BufLimit) begin
          res[1] = '{data: 8'h00, has_byte: 1'b0, eof: 1'b1, status: StOverflow,
                     length: fc_inc};
          push_n = 2'd2;
        end else begin
          res[1] = '{data: crc_byte[7:0], has_byte: 1'b1, eof: 1'b0, status: StOk,
                     length: 13'd0};
          res[2] = '{data: crc_byte[15:8], has_byte: 1'b1, eof: 1'b1, status: StOk,
                     length: fc_inc};
          push_n = 2'd3;
        end
      end
    end else begin
      if (held_count >= 2'd2) begin
        res[0]       = '{data: held0, has_byte: 1'b1, eof: 1'b0, status: StOk,
                         length: 13'd0};
        push_n       = 2'd1;
        crc_acc_next = crc_held;
        held0_next   = held1;
        held1_next   = byte_in;
      end else begin
        if (held_count[0]) begin
          held1_next = byte_in;
        end else begin
          held0_next = byte_in;
        end
        held_count_next = held_count + 2'd1;
      end
      if (frame_end) begin
        res[push_n] = '{data: 8'h00, has_byte: 1'b0, eof: 1'b1, status: StOk,
                        length: len_chk};
        if ({1'b0, fc_inc} > BufLimit) begin
          res[push_n].status = StOverflow;
        end else if (fc_inc < 13'd2) begin
          res[push_n].status = StShort;
        end else if ({held1_next, held0_next} != crc_acc_next) begin
          res[push_n].status = StMismatch;
        end else if (len_chk > max_payload) begin
          res[push_n].status = StOverflow;
        end
        push_n = push_n + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      max_payload <= MaxPayloadInit;
      crc_acc     <= CrcInit;
      held_count  <= 2'd0;
      frame_count <= 13'd0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      q_count     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CfgMode:       mode        <= cfg_data[0];
          CfgMaxPayload: max_payload <= cfg_data;
          default:       mode        <= mode;
        endcase
      end
      if (acc) begin
        if (frame_end) begin
          crc_acc     <= CrcInit;
          held_count  <= 2'd0;
          frame_count <= 13'd0;
        end else begin
          crc_acc     <= crc_acc_next;
          held_count  <= held_count_next;
          frame_count <= fc_inc;
        end
        wr_ptr <= wr_ptr + QPtrW'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      q_count <= q_count + (acc ? QCntW'(push_n) : QCntW'(0)) - (pop ? QCntW'(1) : QCntW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held0 <= held0_next;
      held1 <= held1_next;
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < push_n) begin
          queue[wr_ptr + QPtrW'(k)] <= res[k];
        end
      end
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCntW'(QDepth))
    else $error("Result queue holds more entries than its depth.");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= 2'd2)
    else $error("Held byte count exceeds two.");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    acc && frame_end |=> (frame_count == 13'd0) && (crc_acc == CrcInit) && (held_count == 2'd0))
    else $error("Frame state was not cleared after the last byte.");

  a_append_one: assert property (@(posedge clk) disable iff (rst)
    acc && !mode && !frame_end |=>
      q_count == $past(q_count) + QCntW'(1) - ($past(pop) ? QCntW'(1) : QCntW'(0)))
    else $error("An append-mode byte did not queue exactly one transaction.");

endmodule
